@@ design/vvp_pkg.sv @@
// ============================================================================
// vvp_pkg
// Shared types and constants for the vertex view and projection block.
// ============================================================================
package vvp_pkg;

    // Field widths
    localparam int CoordW  = 20;
    localparam int DistW   = 21;
    localparam int NumW    = 40;
    localparam int QuotW   = 26;
    localparam int DivW    = 20;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ROW_U          = 3'd0,
        REG_ROW_V          = 3'd1,
        REG_ROW_N          = 3'd2,
        REG_EYE_OFFSETS    = 3'd3,
        REG_VIEW_SCALE     = 3'd4,
        REG_EYE_DISTANCE   = 3'd5,
        REG_PLANE_DISTANCE = 3'd6,
        REG_HALF_WINDOW    = 3'd7
    } reg_index_t;

    // Settings used by the view transform
    typedef struct packed {
        logic [47:0]        row_u;
        logic [47:0]        row_v;
        logic [47:0]        row_n;
        logic [59:0]        eye_offsets;
        logic [15:0]        view_scale;
        logic signed [19:0] eye_distance;
    } view_cfg_t;

    // Settings used by the projection
    typedef struct packed {
        logic signed [19:0] plane_distance;
        logic [23:0]        half_window;
    } proj_cfg_t;

    // One transformed vertex request passed from the front to the back
    typedef struct packed {
        logic signed [CoordW-1:0] vx;
        logic signed [CoordW-1:0] vy;
        logic signed [CoordW-1:0] vz;
        logic signed [DistW-1:0]  depth_gap;
        logic                     behind;
        logic                     last;
    } vtx_t;

    // Per-lane sideband carried along the divider pipeline
    typedef struct packed {
        logic neg;
        logic ovf;
    } lane_flags_t;

endpackage

@@ design/vvp_front.sv @@
// ============================================================================
// vvp_front
// View transform pipeline: basis dot products, offset, scale, round and
// saturate, then the projection denominator and the behind-eye flag.
// ============================================================================
module vvp_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  vvp_pkg::view_cfg_t       cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [19:0]       world_x,
    input  logic signed [19:0]       world_y,
    input  logic signed [19:0]       world_z,
    input  logic                     last_in,
    output logic                     item_valid,
    input  logic                     item_full,
    output vvp_pkg::vtx_t            item
);

    logic               en;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [19:0] x_reg, y_reg, z_reg;
    logic               l1_reg, l2_reg, l3_reg, l4_reg;
    logic signed [35:0] prod_reg [9];
    logic signed [35:0] prod_next [9];
    logic signed [37:0] t_reg [3];
    logic signed [37:0] t_next [3];
    logic signed [55:0] p_reg [3];
    logic signed [55:0] p_next [3];
    logic signed [19:0] view_val [3];

    // Saturate a rounded value to a signed 20-bit coordinate.
    function automatic logic signed [19:0] sat_coord(input logic signed [55:0] v);
        logic signed [55:0] hi;
        logic signed [55:0] lo;
        hi = 56'sd524287;
        lo = -56'sd524288;
        if (v > hi)
        begin
            sat_coord = 20'sd524287;
        end
        else if (v < lo)
        begin
            sat_coord = -20'sd524288;
        end
        else
        begin
            sat_coord = v[19:0];
        end
    endfunction

    // The pipeline stalls only when its last stage cannot enter the queue.
    assign en       = !(v4_reg && item_full);
    assign in_ready = en;

    // Nine basis products.
    always_comb
    begin
        logic [47:0]        rows [3];
        logic signed [15:0] c;
        rows[0] = cfg.row_u;
        rows[1] = cfg.row_v;
        rows[2] = cfg.row_n;
        for (int i = 0; i < 3; i++)
        begin
            c = $signed(rows[i][15:0]);
            prod_next[3*i]   = c * x_reg;
            c = $signed(rows[i][31:16]);
            prod_next[3*i+1] = c * y_reg;
            c = $signed(rows[i][47:32]);
            prod_next[3*i+2] = c * z_reg;
        end
    end

    // Dot product sums minus the eye offsets.
    always_comb
    begin
        logic signed [19:0] off;
        logic signed [37:0] offs;
        for (int i = 0; i < 3; i++)
        begin
            off  = $signed(cfg.eye_offsets[20*i +: 20]);
            offs = 38'(off) <<< 14;
            t_next[i] = 38'(prod_reg[3*i]) + 38'(prod_reg[3*i+1])
                      + 38'(prod_reg[3*i+2]) - offs;
        end
    end

    // Scale by the unsigned view scale.
    always_comb
    begin
        logic signed [16:0] sc;
        sc = $signed({1'b0, cfg.view_scale});
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = 56'(t_reg[i]) * 56'(sc);
        end
    end

    // Round half up, drop the fraction and saturate.
    always_comb
    begin
        logic signed [55:0] r;
        for (int i = 0; i < 3; i++)
        begin
            r = (p_reg[i] + (56'sd1 <<< 21)) >>> 22;
            view_val[i] = sat_coord(r);
        end
    end

    // Result toward the queue.
    always_comb
    begin
        item.vx        = view_val[0];
        item.vy        = view_val[1];
        item.vz        = view_val[2];
        item.depth_gap = 21'(cfg.eye_distance) - 21'(view_val[2]);
        item.behind    = (item.depth_gap <= 21'sd0);
        item.last      = l4_reg;
    end
    assign item_valid = v4_reg;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Data stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= world_x;
            y_reg  <= world_y;
            z_reg  <= world_z;
            l1_reg <= last_in;
            l2_reg <= l1_reg;
            l3_reg <= l2_reg;
            l4_reg <= l3_reg;
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i] <= t_next[i];
                p_reg[i] <= p_next[i];
            end
        end
    end

endmodule

@@ design/vvp_queue.sv @@
// ============================================================================
// vvp_queue
// Four-entry queue between the view transform and the projection.
// ============================================================================
module vvp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           full,
    input  vvp_pkg::vtx_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output vvp_pkg::vtx_t  pop_data
);

    vvp_pkg::vtx_t mem_reg [4];
    logic [1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [2:0]    count_reg;
    logic          push, pop;

    assign full      = (count_reg == 3'd4);
    assign pop_valid = (count_reg != 3'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign push      = push_valid && !full;
    assign pop       = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 3'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 3'd1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/vvp_back.sv @@
// ============================================================================
// vvp_back
// Perspective projection: numerator products, a pipelined rounding divider
// with one quotient bit per stage, window offset and saturation.
// ============================================================================
module vvp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  vvp_pkg::proj_cfg_t  cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  vvp_pkg::vtx_t       item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [19:0]  view_x,
    output logic signed [19:0]  view_y,
    output logic signed [19:0]  view_z,
    output logic signed [23:0]  screen_x,
    output logic signed [23:0]  screen_y,
    output logic                behind_eye,
    output logic                last_out
);

    localparam int Steps = vvp_pkg::QuotW;

    logic                               en;
    logic                               m_valid_reg;
    vvp_pkg::vtx_t                      m_vtx_reg;
    logic signed [vvp_pkg::NumW-1:0]    m_num_reg [2];
    logic signed [vvp_pkg::NumW-1:0]    m_num_next [2];

    logic                               dv_valid_reg [Steps+1];
    vvp_pkg::vtx_t                      dv_vtx_reg   [Steps+1];
    vvp_pkg::lane_flags_t               dv_flags_reg [Steps+1][2];
    logic [vvp_pkg::NumW-1:0]           dv_num_reg   [Steps+1][2];
    logic [vvp_pkg::DivW-1:0]           dv_rem_reg   [Steps+1][2];
    logic [Steps-1:0]                   dv_quo_reg   [Steps+1][2];
    logic [vvp_pkg::DivW-1:0]           dv_den_reg   [Steps+1];

    logic [vvp_pkg::NumW-1:0]           n_next [2];
    vvp_pkg::lane_flags_t               f_next [2];
    logic [vvp_pkg::DivW-1:0]           den_next;
    logic signed [23:0]                 scr_next [2];

    logic                               o_valid_reg;
    vvp_pkg::vtx_t                      o_vtx_reg;
    logic signed [23:0]                 o_scr_reg [2];

    // The whole back end advances while the output register can move.
    assign en         = !o_valid_reg || out_ready;
    assign item_ready = en;

    // Numerator products.
    always_comb
    begin
        m_num_next[0] = item.vx * cfg.plane_distance;
        m_num_next[1] = item.vy * cfg.plane_distance;
    end

    // Magnitude plus half the divisor, and the early overflow test.
    always_comb
    begin
        logic [vvp_pkg::NumW-1:0] mag;
        den_next = m_vtx_reg.depth_gap[vvp_pkg::DivW-1:0];
        for (int i = 0; i < 2; i++)
        begin
            f_next[i].neg = m_num_reg[i][vvp_pkg::NumW-1];
            mag = f_next[i].neg ? 40'(-m_num_reg[i]) : 40'(m_num_reg[i]);
            n_next[i] = mag + 40'(den_next >> 1);
            f_next[i].ovf = (20'(n_next[i][vvp_pkg::NumW-1:Steps]) >= den_next);
        end
    end

    // Multiply stage and first divider stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg     <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg     <= item_valid;
            dv_valid_reg[0] <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_vtx_reg     <= item;
            dv_vtx_reg[0] <= m_vtx_reg;
            dv_den_reg[0] <= den_next;
            for (int i = 0; i < 2; i++)
            begin
                m_num_reg[i]       <= m_num_next[i];
                dv_flags_reg[0][i] <= f_next[i];
                dv_num_reg[0][i]   <= n_next[i];
                dv_rem_reg[0][i]   <= 20'(n_next[i][vvp_pkg::NumW-1:Steps]);
                dv_quo_reg[0][i]   <= '0;
            end
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar s = 0; s < Steps; s++)
    begin : g_div
        logic [vvp_pkg::DivW-1:0] rem_next [2];
        logic [Steps-1:0]         quo_next [2];

        always_comb
        begin
            logic [vvp_pkg::DivW:0] r2;
            logic                   ge;
            for (int i = 0; i < 2; i++)
            begin
                r2 = {dv_rem_reg[s][i], dv_num_reg[s][i][Steps-1-s]};
                ge = (r2 >= {1'b0, dv_den_reg[s]});
                rem_next[i] = ge ? 20'(r2 - {1'b0, dv_den_reg[s]}) : r2[vvp_pkg::DivW-1:0];
                quo_next[i] = {dv_quo_reg[s][i][Steps-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[s+1] <= dv_valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_vtx_reg[s+1] <= dv_vtx_reg[s];
                dv_den_reg[s+1] <= dv_den_reg[s];
                for (int i = 0; i < 2; i++)
                begin
                    dv_flags_reg[s+1][i] <= dv_flags_reg[s][i];
                    dv_num_reg[s+1][i]   <= dv_num_reg[s][i];
                    dv_rem_reg[s+1][i]   <= rem_next[i];
                    dv_quo_reg[s+1][i]   <= quo_next[i];
                end
            end
        end
    end

    // Sign, window offset and saturation.
    always_comb
    begin
        logic [Steps:0]     q;
        logic signed [27:0] proj;
        logic signed [28:0] sum;
        logic [11:0]        half;
        for (int i = 0; i < 2; i++)
        begin
            q    = dv_flags_reg[Steps][i].ovf ? (27'd1 << Steps) : {1'b0, dv_quo_reg[Steps][i]};
            proj = dv_flags_reg[Steps][i].neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
            half = cfg.half_window[12*i +: 12];
            sum  = 29'(proj) + $signed({9'd0, half, 8'd0});
            if (dv_vtx_reg[Steps].behind)
            begin
                scr_next[i] = '0;
            end
            else if (sum > 29'sd8388607)
            begin
                scr_next[i] = 24'sd8388607;
            end
            else if (sum < -29'sd8388608)
            begin
                scr_next[i] = -24'sd8388608;
            end
            else
            begin
                scr_next[i] = sum[23:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= dv_valid_reg[Steps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_vtx_reg    <= dv_vtx_reg[Steps];
            o_scr_reg[0] <= scr_next[0];
            o_scr_reg[1] <= scr_next[1];
        end
    end

    assign out_valid  = o_valid_reg;
    assign view_x     = o_vtx_reg.vx;
    assign view_y     = o_vtx_reg.vy;
    assign view_z     = o_vtx_reg.vz;
    assign screen_x   = o_scr_reg[0];
    assign screen_y   = o_scr_reg[1];
    assign behind_eye = o_vtx_reg.behind;
    assign last_out   = o_vtx_reg.last;

endmodule

@@ design/vertex_view_project_top.sv @@
// Path: an accepted vertex passes 4 transform stages, the queue, 2 projection
// set-up stages, 26 divider stages and the output register. Throughput: one
// vertex per cycle while the output is not stalled; the divider is fully
// pipelined, one quotient bit per stage. Stalls on the output hold the
// projection side while the four-entry queue keeps the transform side running
// until it fills. Reset: asynchronous, active low; clears all valid bits and
// restores the configuration registers to their default values.
// ============================================================================
// vertex_view_project_top
// View transform and perspective projection of a stream of world vertices.
// ============================================================================
module vertex_view_project_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [59:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [19:0] world_x,
    input  logic signed [19:0] world_y,
    input  logic signed [19:0] world_z,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [19:0] view_x,
    output logic signed [19:0] view_y,
    output logic signed [19:0] view_z,
    output logic signed [23:0] screen_x,
    output logic signed [23:0] screen_y,
    output logic               behind_eye,
    output logic               last_out
);

    vvp_pkg::view_cfg_t view_cfg_reg;
    vvp_pkg::proj_cfg_t proj_cfg_reg;
    logic               f_valid, q_full, q_valid, q_ready;
    vvp_pkg::vtx_t      f_item, q_item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_cfg_reg.row_u         <= 48'h0000_0000_4000;
            view_cfg_reg.row_v         <= 48'h0000_4000_0000;
            view_cfg_reg.row_n         <= 48'h4000_0000_0000;
            view_cfg_reg.eye_offsets   <= '0;
            view_cfg_reg.view_scale    <= 16'd256;
            view_cfg_reg.eye_distance  <= 20'sd51200;
            proj_cfg_reg.plane_distance <= 20'sd25600;
            proj_cfg_reg.half_window   <= '0;
        end
        else if (cfg_we)
        begin
            case (vvp_pkg::reg_index_t'(cfg_index))
                vvp_pkg::REG_ROW_U:          view_cfg_reg.row_u <= cfg_data[47:0];
                vvp_pkg::REG_ROW_V:          view_cfg_reg.row_v <= cfg_data[47:0];
                vvp_pkg::REG_ROW_N:          view_cfg_reg.row_n <= cfg_data[47:0];
                vvp_pkg::REG_EYE_OFFSETS:    view_cfg_reg.eye_offsets <= cfg_data;
                vvp_pkg::REG_VIEW_SCALE:     view_cfg_reg.view_scale <= cfg_data[15:0];
                vvp_pkg::REG_EYE_DISTANCE:   view_cfg_reg.eye_distance <= cfg_data[19:0];
                vvp_pkg::REG_PLANE_DISTANCE: proj_cfg_reg.plane_distance <= cfg_data[19:0];
                vvp_pkg::REG_HALF_WINDOW:    proj_cfg_reg.half_window <= cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    // View transform.
    vvp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (view_cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .world_x    (world_x),
        .world_y    (world_y),
        .world_z    (world_z),
        .last_in    (last_in),
        .item_valid (f_valid),
        .item_full  (q_full),
        .item       (f_item)
    );

    // Decoupling queue.
    vvp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .full       (q_full),
        .push_data  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_item)
    );

    // Projection.
    vvp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (proj_cfg_reg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .view_x     (view_x),
        .view_y     (view_y),
        .view_z     (view_z),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .behind_eye (behind_eye),
        .last_out   (last_out)
    );

endmodule
